### rtl/tnb_pkg.sv
// Shared types and constants for the triangle normal and bounds core.
package tnb_pkg;

  // Output field widths fixed by the interface.
  localparam int BOX_W  = 24;
  localparam int NORM_W = 16;

  // Squared-length sum, root and long-division numerator widths.
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;
  localparam int NUM_W  = 64;

  // Aligned magnitudes have their top set bit at this position.
  localparam int ALIGN_BIT = 30;

  // Sequencer counter width, enough for the root loop and the divider.
  localparam int CNT_W = 6;
  localparam int ROOT_STEPS = 32;

  // Multiplier operation codes: six cross terms, then three squares.
  localparam int MI_W = 4;
  localparam logic [MI_W-1:0] MI_VY_UZ = 4'd0;
  localparam logic [MI_W-1:0] MI_VZ_UY = 4'd1;
  localparam logic [MI_W-1:0] MI_VZ_UX = 4'd2;
  localparam logic [MI_W-1:0] MI_VX_UZ = 4'd3;
  localparam logic [MI_W-1:0] MI_VX_UY = 4'd4;
  localparam logic [MI_W-1:0] MI_VY_UX = 4'd5;
  localparam logic [MI_W-1:0] MI_SQ_X  = 4'd6;
  localparam logic [MI_W-1:0] MI_SQ_Y  = 4'd7;
  localparam logic [MI_W-1:0] MI_SQ_Z  = 4'd8;
  localparam int NUM_CROSS = 6;
  localparam int NUM_SQ    = 3;

  // Component selects for the divider.
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MAG,
    ST_NORM,
    ST_SQ,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_END,
    ST_FINISH
  } state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic            load;
    logic            mul_go;
    logic [MI_W-1:0] mul_idx;
    logic            mag_load;
    logic            norm_step;
    logic            sqrt_init;
    logic            sqrt_step;
    logic            div_init;
    logic            div_step;
    logic [1:0]      div_sel;
    logic            div_store;
    logic            out_load;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic zero;
    logic norm_done;
  } stat_t;

endpackage

### rtl/triangle_normal_and_bounds_core.sv
// Top level of the triangle normal and bounds core.
//
//   Channel | Handshake          | Beat
//   --------+--------------------+-------------------------------------------
//   in      | in_valid, in_stall | three vertices and last_triangle
//   out     | out_valid, out_stall | unit normal, degenerate flag, box, mesh_done
//
// One triangle is in work at a time. A triangle passes through the multiply phase,
// normalizing, the 32-step square root and three divisions, one per normal component.
// A degenerate triangle skips the root and the divisions once normalizing sees a zero
// normal, and goes straight to the output.
// After reset the block takes a beat at once and starts a new mesh.
// A stalled result stays in the output register while the next triangle is taken.
module triangle_normal_and_bounds_core import tnb_pkg::*; #(
  parameter int COORD_WIDTH      = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] az,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by_coord,
  input  logic signed [COORD_WIDTH-1:0] bz,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic signed [COORD_WIDTH-1:0] cz,
  input  logic                          last_triangle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [NORM_W-1:0]      normal_x,
  output logic signed [NORM_W-1:0]      normal_y,
  output logic signed [NORM_W-1:0]      normal_z,
  output logic                          degenerate,
  output logic signed [BOX_W-1:0]       min_x,
  output logic signed [BOX_W-1:0]       max_x,
  output logic signed [BOX_W-1:0]       min_y,
  output logic signed [BOX_W-1:0]       max_y,
  output logic signed [BOX_W-1:0]       min_z,
  output logic                          mesh_done
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  tnb_ctrl #(
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Datapath.
  tnb_dp #(
    .COORD_WIDTH     (COORD_WIDTH),
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .ax           (ax),
    .ay           (ay),
    .az           (az),
    .bx           (bx),
    .by_coord     (by_coord),
    .bz           (bz),
    .cx           (cx),
    .cy           (cy),
    .cz           (cz),
    .last_triangle(last_triangle),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .degenerate   (degenerate),
    .min_x        (min_x),
    .max_x        (max_x),
    .min_y        (min_y),
    .max_y        (max_y),
    .min_z        (min_z),
    .mesh_done    (mesh_done)
  );

endmodule

### rtl/tnb_ctrl.sv
// Sequencer for the triangle normal and bounds core.
module tnb_ctrl import tnb_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [1:0]         sel, sel_next;
  logic               out_valid_next;

  // State, counters and the result-valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      sel       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sel_next   = sel;
    cmd        = '0;
    cmd.div_sel = sel;
    in_stall   = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        // Six cross terms, then a pass with no issue so the product register drains.
        if (cnt < CNT_W'(NUM_CROSS)) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_idx = MI_W'(cnt);
          cnt_next    = cnt + 1'b1;
        end else begin
          state_next = ST_MAG;
        end
      end
      ST_MAG: begin
        cmd.mag_load = 1'b1;
        state_next   = ST_NORM;
      end
      ST_NORM: begin
        if (stat.zero) begin
          state_next = ST_FINISH;
        end else if (stat.norm_done) begin
          cnt_next   = '0;
          state_next = ST_SQ;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_SQ: begin
        if (cnt < CNT_W'(NUM_SQ)) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_idx = MI_SQ_X + MI_W'(cnt);
          cnt_next    = cnt + 1'b1;
        end else begin
          state_next = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = '0;
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          sel_next   = SEL_X;
          state_next = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(NORMAL_FRAC_BITS)) begin
          state_next = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        cmd.div_store = 1'b1;
        if (sel == SEL_Z) begin
          state_next = ST_FINISH;
        end else begin
          sel_next   = sel + 1'b1;
          state_next = ST_DIV_INIT;
        end
      end
      ST_FINISH: begin
        // Hand the result over once the output register is free.
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A beat accepted starts the multiply phase.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_MUL))
    else $error("accepted beat did not start the multiply phase");

  // A result is never loaded over one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten");

  // Loading a result raises the output valid.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // The divider only serves the three components.
  a_div_sel: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (sel != 2'd3))
    else $error("divider component select out of range");

endmodule

### rtl/tnb_dp.sv
// Datapath: edges, shared multiplier, normalizer, root, divider and bounding box.
module tnb_dp import tnb_pkg::*; #(
  parameter int COORD_WIDTH      = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output stat_t                         stat,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] az,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by_coord,
  input  logic signed [COORD_WIDTH-1:0] bz,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic signed [COORD_WIDTH-1:0] cz,
  input  logic                          last_triangle,
  output logic signed [NORM_W-1:0]      normal_x,
  output logic signed [NORM_W-1:0]      normal_y,
  output logic signed [NORM_W-1:0]      normal_z,
  output logic                          degenerate,
  output logic signed [BOX_W-1:0]       min_x,
  output logic signed [BOX_W-1:0]       max_x,
  output logic signed [BOX_W-1:0]       min_y,
  output logic signed [BOX_W-1:0]       max_y,
  output logic signed [BOX_W-1:0]       min_z,
  output logic                          mesh_done
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 1;
  localparam int AW   = 2 * EW + 1;
  localparam int MAGW = (AW > ALIGN_BIT + 1) ? AW : ALIGN_BIT + 1;
  localparam int MULW = (EW > ALIGN_BIT + 1) ? EW : ALIGN_BIT + 1;
  localparam int QW   = NORMAL_FRAC_BITS + 1;
  localparam int NMAX = 32767;
  localparam int NMIN = -32768;

  function automatic logic [EW-1:0] abs_e(input logic signed [EW-1:0] x);
    return x[EW-1] ? EW'(-x) : EW'(x);
  endfunction

  function automatic logic [AW-1:0] abs_a(input logic signed [AW-1:0] x);
    return x[AW-1] ? AW'(-x) : AW'(x);
  endfunction

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (b > a) ? b : a;
  endfunction

  logic signed [EW-1:0]     u_x, u_y, u_z, v_x, v_y, v_z;
  logic [MULW-1:0]          op_a, op_b;
  logic                     op_neg;
  logic [2*MULW-1:0]        prod;
  logic                     p_neg, p_vld;
  logic [MI_W-1:0]          p_idx;
  logic signed [AW-1:0]     n_acc [3];
  logic [SQ_W-1:0]          s_sum;
  logic [MAGW-1:0]          mag [3];
  logic [2:0]               neg_r;
  logic [MAGW-1:0]          or_all;
  logic [SQ_W-1:0]          sq_n, sq_r, sq_bit;
  logic [SQ_W:0]            sq_t;
  logic [ROOT_W-1:0]        root;
  logic [NUM_W-1:0]         num, nsh;
  logic [ROOT_W-1:0]        rem;
  logic [ROOT_W:0]          div_t;
  logic [QW-1:0]            quo;
  logic signed [QW:0]       q_s;
  logic signed [NORM_W-1:0] packed_n;
  logic signed [NORM_W-1:0] res [3];
  logic                     last_r, expect_first;
  logic signed [CW-1:0]     box_min_x, box_max_x, box_min_y, box_max_y, box_min_z;
  logic signed [CW-1:0]     seed_min_x, seed_max_x, seed_min_y, seed_max_y, seed_min_z;

  // Edge vectors from vertex A.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_x    <= EW'(bx) - EW'(ax);
      u_y    <= EW'(by_coord) - EW'(ay);
      u_z    <= EW'(bz) - EW'(az);
      v_x    <= EW'(cx) - EW'(ax);
      v_y    <= EW'(cy) - EW'(ay);
      v_z    <= EW'(cz) - EW'(az);
      last_r <= last_triangle;
    end
  end

  // Operand select for the shared unsigned multiplier; odd cross terms subtract.
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    case (cmd.mul_idx)
      MI_VY_UZ: begin
        op_a = MULW'(abs_e(v_y)); op_b = MULW'(abs_e(u_z));
        op_neg = v_y[EW-1] ^ u_z[EW-1];
      end
      MI_VZ_UY: begin
        op_a = MULW'(abs_e(v_z)); op_b = MULW'(abs_e(u_y));
        op_neg = ~(v_z[EW-1] ^ u_y[EW-1]);
      end
      MI_VZ_UX: begin
        op_a = MULW'(abs_e(v_z)); op_b = MULW'(abs_e(u_x));
        op_neg = v_z[EW-1] ^ u_x[EW-1];
      end
      MI_VX_UZ: begin
        op_a = MULW'(abs_e(v_x)); op_b = MULW'(abs_e(u_z));
        op_neg = ~(v_x[EW-1] ^ u_z[EW-1]);
      end
      MI_VX_UY: begin
        op_a = MULW'(abs_e(v_x)); op_b = MULW'(abs_e(u_y));
        op_neg = v_x[EW-1] ^ u_y[EW-1];
      end
      MI_VY_UX: begin
        op_a = MULW'(abs_e(v_y)); op_b = MULW'(abs_e(u_x));
        op_neg = ~(v_y[EW-1] ^ u_x[EW-1]);
      end
      MI_SQ_X: begin op_a = MULW'(mag[0]); op_b = MULW'(mag[0]); end
      MI_SQ_Y: begin op_a = MULW'(mag[1]); op_b = MULW'(mag[1]); end
      MI_SQ_Z: begin op_a = MULW'(mag[2]); op_b = MULW'(mag[2]); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // Product register, then accumulation in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= cmd.mul_go;
    end
    prod  <= op_a * op_b;
    p_neg <= op_neg;
    p_idx <= cmd.mul_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_acc[0] <= '0;
      n_acc[1] <= '0;
      n_acc[2] <= '0;
      s_sum    <= '0;
    end else if (p_vld) begin
      if (p_idx < MI_SQ_X) begin
        n_acc[p_idx[2:1]] <= p_neg ? n_acc[p_idx[2:1]] - signed'(AW'(prod))
                                   : n_acc[p_idx[2:1]] + signed'(AW'(prod));
      end else begin
        s_sum <= s_sum + SQ_W'(prod);
      end
    end
  end

  // Magnitudes, then a common shift that puts the top set bit at bit 30.
  assign or_all         = mag[0] | mag[1] | mag[2];
  assign stat.zero      = (or_all == '0);
  assign stat.norm_done = ((or_all >> (ALIGN_BIT + 1)) == '0) && or_all[ALIGN_BIT];

  always_ff @(posedge clk) begin
    if (cmd.mag_load) begin
      for (int i = 0; i < 3; i++) begin
        mag[i]   <= MAGW'(abs_a(n_acc[i]));
        neg_r[i] <= n_acc[i][AW-1];
      end
    end else if (cmd.norm_step) begin
      for (int i = 0; i < 3; i++) begin
        if ((or_all >> (ALIGN_BIT + 8)) != '0) begin
          mag[i] <= mag[i] >> 8;
        end else if ((or_all >> (ALIGN_BIT + 1)) != '0) begin
          mag[i] <= mag[i] >> 1;
        end else if ((or_all >> (ALIGN_BIT - 7)) == '0) begin
          mag[i] <= mag[i] << 8;
        end else begin
          mag[i] <= mag[i] << 1;
        end
      end
    end
  end

  // Integer square root, one result bit per cycle.
  assign sq_t = {1'b0, sq_r} + {1'b0, sq_bit};
  assign root = sq_r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_n   <= s_sum;
      sq_r   <= '0;
      sq_bit <= SQ_W'(1) << (SQ_W - 2);
    end else if (cmd.sqrt_step) begin
      if ({1'b0, sq_n} >= sq_t) begin
        sq_n <= sq_n - sq_t[SQ_W-1:0];
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // Restoring divider for the rounded quotient, one bit per cycle.
  assign num   = (NUM_W'(mag[cmd.div_sel][ALIGN_BIT:0]) << NORMAL_FRAC_BITS)
               + NUM_W'(root >> 1);
  assign div_t = {rem, nsh[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= ROOT_W'(num >> QW);
      nsh <= num << (NUM_W - QW);
      quo <= '0;
    end else if (cmd.div_step) begin
      if (div_t >= {1'b0, root}) begin
        rem <= ROOT_W'(div_t - {1'b0, root});
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= div_t[ROOT_W-1:0];
        quo <= {quo[QW-2:0], 1'b0};
      end
      nsh <= nsh << 1;
    end
  end

  // Sign and saturate to the 16-bit normal field.
  always_comb begin
    q_s = neg_r[cmd.div_sel] ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    if (q_s > NMAX) begin
      packed_n = NORM_W'(NMAX);
    end else if (q_s < NMIN) begin
      packed_n = NORM_W'(NMIN);
    end else begin
      packed_n = NORM_W'(q_s);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      res[cmd.div_sel] <= packed_n;
    end
  end

  // Running box: the first triangle of a mesh seeds it with vertex A.
  always_comb begin
    seed_min_x = expect_first ? ax : box_min_x;
    seed_max_x = expect_first ? ax : box_max_x;
    seed_min_y = expect_first ? ay : box_min_y;
    seed_max_y = expect_first ? ay : box_max_y;
    seed_min_z = expect_first ? az : box_min_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_first <= 1'b1;
    end else if (cmd.load) begin
      expect_first <= last_triangle;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      box_min_x <= smin(smin(smin(seed_min_x, ax), bx), cx);
      box_max_x <= smax(smax(smax(seed_max_x, ax), bx), cx);
      box_min_y <= smin(smin(smin(seed_min_y, ay), by_coord), cy);
      box_max_y <= smax(smax(smax(seed_max_y, ay), by_coord), cy);
      box_min_z <= smin(smin(smin(seed_min_z, az), bz), cz);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      normal_x   <= stat.zero ? '0 : res[0];
      normal_y   <= stat.zero ? '0 : res[1];
      normal_z   <= stat.zero ? '0 : res[2];
      degenerate <= stat.zero;
      min_x      <= BOX_W'(box_min_x);
      max_x      <= BOX_W'(box_max_x);
      min_y      <= BOX_W'(box_min_y);
      max_y      <= BOX_W'(box_max_y);
      min_z      <= BOX_W'(box_min_z);
      mesh_done  <= last_r;
    end
  end

endmodule
